/* hdl/gbm_pkg.sv */
// Shared types and constants for the glyph brightness matcher.
package gbm_pkg;

   localparam int MAX_GLYPHS_DEFAULT = 16;
   localparam int NUM_REGIONS        = 5;
   localparam int BRIGHT_W           = 8;
   localparam int CODE_W             = 16;
   localparam int SLOT_W             = 4;
   localparam int INDEX_W            = 4;
   localparam int CSR_W              = 5;
   // Four times a sum distance; also the divider width.
   localparam int DIST4_W            = 13;

   localparam logic [CODE_W-1:0] BLANK_CODE = 16'd32;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_MATCH = 1'b1;

   typedef logic [BRIGHT_W-1:0] bright_type;

   typedef struct packed {
      logic [CODE_W-1:0]                code;
      bright_type [NUM_REGIONS-1:0]     bright;
   } glyph_entry_type;

   typedef struct packed {
      logic [CODE_W-1:0] match_code;
      logic [SLOT_W-1:0] match_slot;
      logic              empty_flag;
   } match_result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_KSTEP,
      ST_LIM,
      ST_REGION,
      ST_DIV,
      ST_MUL,
      ST_COUNT,
      ST_DONE
   } state_type;

endpackage

/* hdl/glyph_brightness_matcher.sv */
// Top level of the glyph brightness matcher: configuration, output register, wiring.
// A load item writes one glyph slot and is done in the cycle it is accepted; the next
// item may follow at once. A match item works on the n glyphs in use: the table is
// scanned three times through its single read port at one entry per cycle (sum
// distance, region distance, region count), and a restoring divider (13 quotient bits)
// sets the region step between the second and third scans. With an empty table the
// match skips the scans and goes straight to its result. One item is worked at a time;
// the result sits in an output register, so the next item is taken while it waits to
// be collected. The glyph table is not cleared by reset: slots must be loaded before
// symbol_count covers them.
module glyph_brightness_matcher import gbm_pkg::*; #(
   parameter int MAX_GLYPHS = MAX_GLYPHS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [CODE_W-1:0]   req_glyph_code,
   input  logic [BRIGHT_W-1:0] req_bright_center,
   input  logic [BRIGHT_W-1:0] req_bright_left,
   input  logic [BRIGHT_W-1:0] req_bright_right,
   input  logic [BRIGHT_W-1:0] req_bright_up,
   input  logic [BRIGHT_W-1:0] req_bright_down,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CODE_W-1:0]   rsp_match_code,
   output logic [SLOT_W-1:0]   rsp_match_slot,
   output logic                rsp_empty_flag,
   // configuration
   input  logic                csr_wr_en,
   input  logic [CSR_W-1:0]    csr_wr_data
);

   localparam int AddrW = $clog2(MAX_GLYPHS);

   logic [CSR_W-1:0]  symbol_count_ff, symbol_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   match_result_type  rsp_data_ff, rsp_data_in;

   logic              core_ready;
   logic              req_accept;
   logic              out_free;
   logic              res_valid;
   match_result_type  res_data;
   glyph_entry_type   req_glyph;

   logic              wr_en;
   logic [AddrW-1:0]  wr_addr;
   glyph_entry_type   wr_data;
   logic              rd_en;
   logic [AddrW-1:0]  rd_addr;
   glyph_entry_type   rd_data;

   logic               div_start;
   logic [DIST4_W-1:0] div_dividend;
   logic [DIST4_W-1:0] div_divisor;
   logic               div_done;
   logic [DIST4_W-1:0] div_quotient;

   assign req_stall  = !core_ready;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      req_glyph.code      = req_glyph_code;
      req_glyph.bright[0] = req_bright_center;
      req_glyph.bright[1] = req_bright_left;
      req_glyph.bright[2] = req_bright_right;
      req_glyph.bright[3] = req_bright_up;
      req_glyph.bright[4] = req_bright_down;
   end

   always_comb begin
      symbol_count_in = csr_wr_en ? csr_wr_data : symbol_count_ff;
      // hold a stalled item, load a new one when the slot frees up
      rsp_valid_in    = res_valid || (rsp_valid_ff && rsp_stall);
      rsp_data_in     = res_valid ? res_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         symbol_count_ff <= symbol_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_match_code = rsp_data_ff.match_code;
   assign rsp_match_slot = rsp_data_ff.match_slot;
   assign rsp_empty_flag = rsp_data_ff.empty_flag;

   gbm_store #(
      .MAX_GLYPHS (MAX_GLYPHS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gbm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   gbm_scan #(
      .MAX_GLYPHS (MAX_GLYPHS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (req_accept),
      .item_type    (req_type),
      .item_index   (req_entry_index),
      .item_glyph   (req_glyph),
      .symbol_count (symbol_count_ff),
      .ready        (core_ready),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res_data     (res_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

endmodule

/* hdl/gbm_store.sv */
// Glyph table: one write port, one registered read port.
module gbm_store import gbm_pkg::*; #(
   parameter int MAX_GLYPHS = MAX_GLYPHS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_GLYPHS)-1:0] wr_addr,
   input  glyph_entry_type               wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_GLYPHS)-1:0] rd_addr,
   output glyph_entry_type               rd_data
);

   glyph_entry_type mem [MAX_GLYPHS];
   glyph_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/gbm_div.sv */
// Restoring divider, one quotient bit per cycle.
module gbm_div import gbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIST4_W-1:0] dividend,
   input  logic [DIST4_W-1:0] divisor,
   output logic               done,
   output logic [DIST4_W-1:0] quotient
);

   localparam int CntW = $clog2(DIST4_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [DIST4_W:0]   rem_ff, rem_in;
   logic [DIST4_W-1:0] quo_ff, quo_in;

   logic [DIST4_W:0]   shifted;
   logic [DIST4_W:0]   diff;
   logic               fits;

   always_comb begin
      shifted = {rem_ff[DIST4_W-1:0], quo_ff[DIST4_W-1]};
      fits    = shifted >= {1'b0, divisor};
      diff    = shifted - {1'b0, divisor};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(DIST4_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff : shifted;
         quo_in = {quo_ff[DIST4_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/gbm_scan.sv */
// Match sequencer: three scans over the glyph table plus the step arithmetic.
module gbm_scan import gbm_pkg::*; #(
   parameter int MAX_GLYPHS = MAX_GLYPHS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // item from the request channel
   input  logic                          start,
   input  logic                          item_type,
   input  logic [INDEX_W-1:0]            item_index,
   input  glyph_entry_type               item_glyph,
   input  logic [CSR_W-1:0]              symbol_count,
   output logic                          ready,
   // result toward the output register
   input  logic                          out_free,
   output logic                          res_valid,
   output match_result_type              res_data,
   // glyph table
   output logic                          wr_en,
   output logic [$clog2(MAX_GLYPHS)-1:0] wr_addr,
   output glyph_entry_type               wr_data,
   output logic                          rd_en,
   output logic [$clog2(MAX_GLYPHS)-1:0] rd_addr,
   input  glyph_entry_type               rd_data,
   // divider
   output logic                          div_start,
   output logic [DIST4_W-1:0]            div_dividend,
   output logic [DIST4_W-1:0]            div_divisor,
   input  logic                          div_done,
   input  logic [DIST4_W-1:0]            div_quotient
);

   localparam int AddrW       = $clog2(MAX_GLYPHS);
   localparam int CountW      = $clog2(MAX_GLYPHS + 1);
   localparam int CmpW        = (CountW > CSR_W) ? CountW : CSR_W;
   localparam int SumW        = 11;
   localparam int LimW        = 14;
   localparam int KW          = 7;
   localparam int FitW        = 3;
   localparam int StepNum     = 51;
   // floor(x / 51) == (x * RecipMul) >> RecipShift for every x below 5609
   localparam int RecipShift  = 18;
   localparam int RecipMul    = 5141;
   localparam int RecipW      = DIST4_W + RecipShift;

   state_type state_ff, state_in;

   logic [CountW-1:0] issue_cnt_ff, issue_cnt_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [AddrW-1:0]  rd_idx_ff, rd_idx_in;
   logic [CountW-1:0] n_ff, n_in;
   logic [SumW-1:0]   s_ff, s_in;
   logic [SumW-1:0]   dmin_ff, dmin_in;
   logic [SumW-1:0]   rmin_ff, rmin_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [LimW-1:0]   lim_ff, lim_in;
   logic [LimW-1:0]   limm_ff, limm_in;
   logic [FitW-1:0]   bestcnt_ff, bestcnt_in;
   logic [AddrW-1:0]  best_slot_ff, best_slot_in;
   logic [CODE_W-1:0] best_code_ff, best_code_in;
   logic              empty_ff, empty_in;

   logic              scanning;
   logic              issue_more;
   logic              pass_end;
   logic              is_match;
   logic [CountW-1:0] n_sat;
   logic [SumW-1:0]   cell_sum;
   logic [SumW-1:0]   g_sum;
   logic [SumW-1:0]   g_dist;
   logic              g_kept;
   logic [SumW-1:0]   five_r;
   logic [SumW-1:0]   r_dist;
   logic [SumW-1:0]   r_min;
   logic [FitW-1:0]   r_fit;
   logic [FitW-1:0]   g_count;
   logic [RecipW-1:0] recip_prod;
   logic [DIST4_W:0]  m_val;
   logic [2*LimW-1:0] limm_prod;

   assign scanning   = (state_ff == ST_SUM) || (state_ff == ST_REGION) || (state_ff == ST_COUNT);
   assign issue_more = issue_cnt_ff < n_ff;
   assign pass_end   = !issue_more && !rd_valid_ff;
   assign is_match   = start && (item_type == REQ_MATCH);

   // cell sum and table size at the start of a match
   always_comb begin
      cell_sum = '0;
      for (int j = 0; j < NUM_REGIONS; j++) begin
         cell_sum = cell_sum + SumW'(item_glyph.bright[j]);
      end
      if (CmpW'(symbol_count) > CmpW'(MAX_GLYPHS)) begin
         n_sat = CountW'(MAX_GLYPHS);
      end else begin
         n_sat = CountW'(symbol_count);
      end
   end

   // per-entry scoring of the word just read
   always_comb begin
      g_sum = '0;
      for (int j = 0; j < NUM_REGIONS; j++) begin
         g_sum = g_sum + SumW'(rd_data.bright[j]);
      end
      g_dist = (g_sum > s_ff) ? (g_sum - s_ff) : (s_ff - g_sum);
      g_kept = {1'b0, g_dist, 2'b00} < lim_ff;

      r_min = '1;
      r_fit = '0;
      for (int j = 0; j < NUM_REGIONS; j++) begin
         five_r = SumW'({rd_data.bright[j], 2'b00}) + SumW'(rd_data.bright[j]);
         r_dist = (five_r > s_ff) ? (five_r - s_ff) : (s_ff - five_r);
         if (r_dist < r_min) begin
            r_min = r_dist;
         end
         if ({1'b0, r_dist, 2'b00} < limm_ff) begin
            r_fit = r_fit + 1'b1;
         end
      end
      g_count = g_kept ? r_fit : '0;
   end

   assign recip_prod = RecipW'({dmin_ff, 2'b00}) * RecipW'(RecipMul);
   assign m_val      = {1'b0, div_quotient} + 1'b1;
   assign limm_prod  = (2*LimW)'(lim_ff) * (2*LimW)'(m_val);

   // datapath next values
   always_comb begin
      n_in         = n_ff;
      s_in         = s_ff;
      dmin_in      = dmin_ff;
      rmin_in      = rmin_ff;
      k_in         = k_ff;
      lim_in       = lim_ff;
      limm_in      = limm_ff;
      bestcnt_in   = bestcnt_ff;
      best_slot_in = best_slot_ff;
      best_code_in = best_code_ff;
      empty_in     = empty_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = issue_cnt_ff[AddrW-1:0];

      if (scanning) begin
         if (issue_more) begin
            issue_cnt_in = issue_cnt_ff + 1'b1;
            rd_valid_in  = 1'b1;
         end else if (pass_end) begin
            issue_cnt_in = '0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            issue_cnt_in = '0;
            if (is_match) begin
               n_in         = n_sat;
               s_in         = cell_sum;
               dmin_in      = '1;
               rmin_in      = '1;
               empty_in     = (n_sat == '0);
               best_code_in = BLANK_CODE;
               best_slot_in = '0;
               bestcnt_in   = '0;
            end
         end
         ST_SUM: begin
            if (rd_valid_ff && (g_dist < dmin_ff)) begin
               dmin_in = g_dist;
            end
         end
         ST_KSTEP: begin
            k_in = recip_prod[RecipShift +: KW] + 1'b1;
         end
         ST_LIM: begin
            lim_in = LimW'(k_ff) * LimW'(StepNum);
         end
         ST_REGION: begin
            if (rd_valid_ff && g_kept && (r_min < rmin_ff)) begin
               rmin_in = r_min;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               limm_in = limm_prod[LimW-1:0];
            end
         end
         ST_MUL: begin
         end
         ST_COUNT: begin
            // first entry always seeds the best; later ones must beat it
            if (rd_valid_ff && ((rd_idx_ff == '0) || (g_count > bestcnt_ff))) begin
               bestcnt_in   = g_count;
               best_slot_in = rd_idx_ff;
               best_code_in = rd_data.code;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_match) begin
               state_in = (n_sat == '0) ? ST_DONE : ST_SUM;
            end
         end
         ST_SUM: begin
            if (pass_end) begin
               state_in = ST_KSTEP;
            end
         end
         ST_KSTEP: begin
            state_in = ST_LIM;
         end
         ST_LIM: begin
            state_in = ST_REGION;
         end
         ST_REGION: begin
            if (pass_end) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (pass_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ready        = (state_ff == ST_IDLE);
      wr_en        = (state_ff == ST_IDLE) && start && (item_type == REQ_LOAD) &&
                     (32'(item_index) < 32'(MAX_GLYPHS));
      wr_addr      = AddrW'(item_index);
      wr_data      = item_glyph;
      rd_en        = scanning && issue_more;
      rd_addr      = issue_cnt_ff[AddrW-1:0];
      div_start    = (state_ff == ST_REGION) && pass_end;
      div_dividend = {rmin_ff, 2'b00};
      div_divisor  = lim_ff[DIST4_W-1:0];
      res_valid    = (state_ff == ST_DONE) && out_free;
      res_data.match_code = best_code_ff;
      res_data.match_slot = SLOT_W'(best_slot_ff);
      res_data.empty_flag = empty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_cnt_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      n_ff         <= n_in;
      s_ff         <= s_in;
      dmin_ff      <= dmin_in;
      rmin_ff      <= rmin_in;
      k_ff         <= k_in;
      lim_ff       <= lim_in;
      limm_ff      <= limm_in;
      bestcnt_ff   <= bestcnt_in;
      best_slot_ff <= best_slot_in;
      best_code_ff <= best_code_in;
      empty_ff     <= empty_in;
   end

`ifndef NO_ASSERTIONS
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SUM || state_ff == ST_REGION || state_ff == ST_COUNT))
      else $error("table read data arrived outside a scan");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      scanning |-> (issue_cnt_ff <= n_ff))
      else $error("scan ran past the table size");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("table written and read in the same cycle");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");
`endif

endmodule
